// File: rtl/yuyv_raster_to_mcu_reorder_defines.svh
// Assertion macros for the RTL file that checks itself.
`ifndef YUYV_RASTER_TO_MCU_REORDER_DEFINES_SVH
`define YUYV_RASTER_TO_MCU_REORDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YRMR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define YRMR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/yrmr_pkg.sv
`default_nettype none

package yrmr_pkg;

   typedef enum logic [1:0] {
      ACT_PAIR  = 2'd0,
      ACT_EOL   = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_READ  = 2'd3
   } yrmr_action_type;

   // Which buffer plane answers a read; none means the answer is zero.
   typedef enum logic [1:0] {
      PLANE_NONE = 2'd0,
      PLANE_LUMA = 2'd1,
      PLANE_CB   = 2'd2,
      PLANE_CR   = 2'd3
   } yrmr_plane_type;

   typedef struct packed {
      logic pair_dropped;
      logic first_band;
      logic band_ready;
   } yrmr_flags_type;

   localparam int PIXELS_PER_MCU = 16;
   localparam int MCU_PAIRS      = 8;
   localparam int MCU_BYTES      = 256;
   localparam int PLANE_WORDS    = 64;
   localparam logic [2:0] ROW_LAST = 3'h7;

endpackage

`default_nettype wire

// File: rtl/yrmr_ram.sv
`default_nettype none

module yrmr_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/yrmr_ctrl.sv
`default_nettype none

module yrmr_ctrl #(
   parameter  int LINE_PIXELS = 320,
   localparam int MCUS        = LINE_PIXELS / 16,
   localparam int AW          = $clog2(MCUS * 64)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  yrmr_pkg::yrmr_action_type action,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_luma_addr,
   output logic [AW-1:0]             wr_chroma_addr,
   output yrmr_pkg::yrmr_flags_type  flags
);

   import yrmr_pkg::*;

   localparam int PAIR_LIMIT = MCUS * MCU_PAIRS;
   localparam int CW         = $clog2(PAIR_LIMIT + 1);

   logic [CW-1:0] col_ff, col_in;
   logic [2:0]    row_ff, row_in;
   logic          past_ff, past_in;
   logic [2:0]    pair_in_mcu;

   assign pair_in_mcu = col_ff[2:0];

   // Luma: left 8x8 block in low words, right in high; chroma is one byte per pair.
   assign wr_luma_addr   = AW'({col_ff[CW-1:3], pair_in_mcu[2], row_ff, pair_in_mcu[1:0]});
   assign wr_chroma_addr = AW'({col_ff[CW-1:3], row_ff, pair_in_mcu});

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      past_in = past_ff;
      flags   = '0;
      wr_en   = 1'b0;
      unique case (action)
         ACT_PAIR: begin
            if (col_ff < CW'(PAIR_LIMIT)) begin
               wr_en  = accept;
               col_in = col_ff + CW'(1);
            end else begin
               flags.pair_dropped = 1'b1;
            end
         end
         ACT_EOL: begin
            if (row_ff == ROW_LAST) begin
               flags.band_ready = 1'b1;
               flags.first_band = !past_ff;
               past_in          = 1'b1;
            end
            row_in = row_ff + 3'd1;
            col_in = '0;
         end
         ACT_FRAME: begin
            col_in  = '0;
            row_in  = '0;
            past_in = 1'b0;
         end
         ACT_READ: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         past_ff <= 1'b0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         past_ff <= past_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/yuyv_raster_to_mcu_reorder.sv
// An accepted item passes through stage one (the memory read) and the output register.
// Throughput: one item per cycle unless the output stalls; each pixel pair is a single
// write into each of the luma (16-bit words), Cb and Cr memories, and a read is one
// registered memory access. Reset clears the line counters, the band flags and the
// pipeline valids; buffer contents are undefined until written and are not cleared.
`default_nettype none

`include "yuyv_raster_to_mcu_reorder_defines.svh"

module yuyv_raster_to_mcu_reorder #(
   parameter int LINE_PIXELS = 320
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24],
   // read_address[44:32], zero fill [47:45]
   input  logic [47:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata,
   // band_ready[0], first_band[1], pair_dropped[2]
   output logic [2:0]  rsp_tuser
);

   import yrmr_pkg::*;

   localparam int MCUS       = LINE_PIXELS / PIXELS_PER_MCU;
   localparam int WORD_DEPTH = MCUS * PLANE_WORDS;
   localparam int AW         = $clog2(WORD_DEPTH);
   localparam int READ_LIMIT = MCUS * MCU_BYTES;

   yrmr_action_type action;
   logic [7:0]      luma_first, chroma_blue, luma_second, chroma_red;
   logic [12:0]     read_address;
   logic            accept;

   assign action       = yrmr_action_type'(req_tuser);
   assign luma_first   = req_tdata[7:0];
   assign chroma_blue  = req_tdata[15:8];
   assign luma_second  = req_tdata[23:16];
   assign chroma_red   = req_tdata[31:24];
   assign read_address = req_tdata[44:32];

   logic           wr_en;
   logic [AW-1:0]  wr_luma_addr, wr_chroma_addr;
   yrmr_flags_type flags;

   yrmr_ctrl #(
      .LINE_PIXELS (LINE_PIXELS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .action         (action),
      .wr_en          (wr_en),
      .wr_luma_addr   (wr_luma_addr),
      .wr_chroma_addr (wr_chroma_addr),
      .flags          (flags)
   );

   // Read side: decode the byte offset inside its MCU into plane and word.
   logic           rd_en;
   logic [AW-1:0]  rd_luma_addr, rd_chroma_addr;
   yrmr_plane_type plane;

   assign rd_en          = accept && (action == ACT_READ);
   assign rd_luma_addr   = AW'({read_address[12:8], read_address[6:1]});
   assign rd_chroma_addr = AW'({read_address[12:8], read_address[5:0]});

   always_comb begin
      if (action != ACT_READ || 32'(read_address) >= READ_LIMIT) begin
         plane = PLANE_NONE;
      end else if (!read_address[7]) begin
         plane = PLANE_LUMA;
      end else if (!read_address[6]) begin
         plane = PLANE_CB;
      end else begin
         plane = PLANE_CR;
      end
   end

   logic [15:0] luma_rd;
   logic [7:0]  cb_rd, cr_rd;

   yrmr_ram #(.WIDTH(16), .DEPTH(WORD_DEPTH)) u_luma_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_luma_addr),
      .wr_data ({luma_second, luma_first}),
      .rd_en   (rd_en),
      .rd_addr (rd_luma_addr),
      .rd_data (luma_rd)
   );

   yrmr_ram #(.WIDTH(8), .DEPTH(WORD_DEPTH)) u_cb_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_chroma_addr),
      .wr_data (chroma_blue),
      .rd_en   (rd_en),
      .rd_addr (rd_chroma_addr),
      .rd_data (cb_rd)
   );

   yrmr_ram #(.WIDTH(8), .DEPTH(WORD_DEPTH)) u_cr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_chroma_addr),
      .wr_data (chroma_red),
      .rd_en   (rd_en),
      .rd_addr (rd_chroma_addr),
      .rd_data (cr_rd)
   );

   // Stage one waits on the memory read; stage two is the output register.
   logic           s1_valid_ff;
   yrmr_flags_type s1_flags_ff;
   yrmr_plane_type s1_plane_ff;
   logic           s1_byte_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   yrmr_flags_type rsp_flags_ff;
   logic           out_free, s1_move;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      unique case (s1_plane_ff)
         PLANE_NONE: rsp_data_in = '0;
         PLANE_LUMA: rsp_data_in = s1_byte_ff ? luma_rd[15:8] : luma_rd[7:0];
         PLANE_CB:   rsp_data_in = cb_rd;
         PLANE_CR:   rsp_data_in = cr_rd;
         default:    rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
         s1_plane_ff <= plane;
         s1_byte_ff  <= read_address[0];
      end
      if (s1_move) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_flags_ff <= s1_flags_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flags_ff;

   `YRMR_ASSERT_SAME(a_first_needs_ready, s1_valid_ff && s1_flags_ff.first_band,
                     s1_flags_ff.band_ready)
   `YRMR_ASSERT_SAME(a_flags_exclusive, s1_valid_ff && s1_flags_ff.pair_dropped,
                     !s1_flags_ff.band_ready && s1_plane_ff == PLANE_NONE)
   `YRMR_ASSERT_SAME(a_stall_blocks_input, s1_valid_ff && !out_free, !req_tready)
   `YRMR_ASSERT_NEXT(a_move_fills_output, s1_move, rsp_valid_ff)

endmodule

`default_nettype wire

// File: bench/yuyv_raster_to_mcu_reorder_tb.sv
module yuyv_raster_to_mcu_reorder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import yrmr_pkg::*;

   localparam int LINE_PIXELS    = 320;
   localparam int PAIR_LIMIT     = (LINE_PIXELS / PIXELS_PER_MCU) * MCU_PAIRS;
   localparam int BAND_BYTES     = (LINE_PIXELS / PIXELS_PER_MCU) * MCU_BYTES;
   localparam int CB_OFFSET      = 2 * PLANE_WORDS;
   localparam int CR_OFFSET      = 3 * PLANE_WORDS;
   localparam int ADDR_MAX       = 8191;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [7:0]     read_data;
      yrmr_flags_type flags;
   } reorder_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24],
   // read_address[44:32], zero fill [47:45]
   logic [47:0] req_tdata = '0;
   // action[1:0]
   logic [1:0]  req_tuser = ACT_PAIR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // read_data[7:0]
   logic [7:0]  rsp_tdata;
   // band_ready[0], first_band[1], pair_dropped[2]
   logic [2:0]  rsp_tuser;

   // Mirror of the band buffer and the line counters.
   logic [7:0]      band_mem [0:BAND_BYTES-1];
   bit              byte_written [0:BAND_BYTES-1];
   int              written_addrs [$];
   int              pair_col = 0;
   logic [2:0]      line_row = '0;
   bit              band_seen = 1'b0;

   reorder_result_type reorder_results_q [$];
   bit              gaps_enabled = 1'b1;
   bit              rsp_hold_request = 1'b0;
   int              items_sent = 0;
   int              results_seen = 0;
   int              mismatches = 0;
   int              bands_checked = 0;
   int              drops_checked = 0;

   yuyv_raster_to_mcu_reorder #(
      .LINE_PIXELS(LINE_PIXELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void store_byte(int addr, logic [7:0] value);
      band_mem[addr] = value;
      if (!byte_written[addr]) begin
         byte_written[addr] = 1'b1;
         written_addrs.push_back(addr);
      end
   endfunction

   // Scatters a pixel pair into the mirrored MCU layout, or answers a
   // control or read item, and returns the result the block must give.
   function automatic reorder_result_type reorder_step(yrmr_action_type act,
                                                       logic [31:0] pixels,
                                                       logic [12:0] addr);
      reorder_result_type r;
      int mcu_idx, col, base, luma_off;
      r = '0;
      case (act)
         ACT_PAIR: begin
            if (pair_col >= PAIR_LIMIT) begin
               r.flags.pair_dropped = 1'b1;
            end else begin
               mcu_idx  = pair_col / MCU_PAIRS;
               col      = pair_col % MCU_PAIRS;
               base     = mcu_idx * MCU_BYTES + int'(line_row) * 8;
               // The left luma block takes columns 0-3, the right one 4-7.
               luma_off = (col < 4) ? 2 * col : PLANE_WORDS + 2 * (col - 4);
               store_byte(base + luma_off, pixels[7:0]);
               store_byte(base + luma_off + 1, pixels[23:16]);
               store_byte(base + CB_OFFSET + col, pixels[15:8]);
               store_byte(base + CR_OFFSET + col, pixels[31:24]);
               pair_col++;
            end
         end
         ACT_EOL: begin
            if (line_row == ROW_LAST) begin
               r.flags.band_ready = 1'b1;
               r.flags.first_band = !band_seen;
               band_seen = 1'b1;
            end
            line_row = line_row + 3'd1;
            pair_col = 0;
         end
         ACT_FRAME: begin
            pair_col  = 0;
            line_row  = '0;
            band_seen = 1'b0;
         end
         default: begin
            if (addr < BAND_BYTES) r.read_data = band_mem[addr];
         end
      endcase
      return r;
   endfunction

   function automatic logic [12:0] any_written_addr();
      return 13'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
   endfunction

   function automatic void report_mismatch(string field, int exp_v, int act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s at result %0d: expected %0d, got %0d",
                  field, results_seen, exp_v, act_v);
   endfunction

   // Offers one item after an optional gap and waits until it is taken.
   // Valid stays high afterwards so that a following item can go back to back.
   task automatic send_item(input yrmr_action_type act, input logic [31:0] pixels,
                            input logic [12:0] addr);
      int gap;
      gap = gaps_enabled ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, addr, pixels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reorder_results_q.push_back(reorder_step(act, pixels, addr));
      items_sent++;
   endtask

   task automatic send_pair(input logic [31:0] pixels);
      send_item(ACT_PAIR, pixels, 13'($urandom_range(0, ADDR_MAX)));
   endtask

   task automatic send_read(input logic [12:0] addr);
      send_item(ACT_READ, $urandom(), addr);
   endtask

   task automatic send_ctrl(input yrmr_action_type act);
      send_item(act, $urandom(), 13'($urandom_range(0, ADDR_MAX)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (reorder_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_ctrl(ACT_FRAME);
      send_pair(32'h0000_0000);
      send_pair(32'hFFFF_FFFF);
      send_pair(32'hC33C_5AA5);
      send_read(13'd0);
      send_read(13'd1);
      send_read(13'd128);
      send_read(13'd192);
      send_read(13'd3);
      send_read(13'd193);
      // Addresses past the buffer answer zero.
      send_read(13'(BAND_BYTES));
      send_read(13'(ADDR_MAX));
      // Eight line ends wrap the row and complete the frame's first band.
      repeat (8) send_ctrl(ACT_EOL);
      send_ctrl(ACT_EOL);
      send_ctrl(ACT_FRAME);
      send_read(13'd2);
   endtask

   task automatic test_line_overflow();
      send_ctrl(ACT_FRAME);
      repeat (PAIR_LIMIT + 3) send_pair($urandom());
      send_ctrl(ACT_EOL);
      repeat (6) send_read(any_written_addr());
   endtask

   task automatic test_backpressure();
      gaps_enabled     = 1'b0;
      rsp_hold_request = 1'b1;
      repeat (48) begin
         if ($urandom_range(0, 3) == 0) send_read(any_written_addr());
         else send_pair($urandom());
      end
      wait_drained();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_frames(input int item_goal);
      int stop_at, line_pairs, pick;
      stop_at = items_sent + item_goal;
      while (items_sent < stop_at) begin
         gaps_enabled = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_ctrl(ACT_FRAME);
         end else if (pick < 85) begin
            // A complete line, mostly short, sometimes full or overflowing.
            pick = $urandom_range(0, 99);
            if (pick < 87) line_pairs = $urandom_range(1, 24);
            else if (pick < 97) line_pairs = $urandom_range(25, PAIR_LIMIT);
            else line_pairs = $urandom_range(PAIR_LIMIT, PAIR_LIMIT + 5);
            repeat (line_pairs) begin
               send_pair($urandom());
               if ($urandom_range(0, 9) == 0) send_read(any_written_addr());
            end
            send_ctrl(ACT_EOL);
         end else begin
            case ($urandom_range(0, 3))
               0: send_pair($urandom());
               1: send_ctrl(ACT_EOL);
               2: send_ctrl(ACT_FRAME);
               default: begin
                  if ($urandom_range(0, 3) == 0)
                     send_read(13'($urandom_range(BAND_BYTES, ADDR_MAX)));
                  else
                     send_read(any_written_addr());
               end
            endcase
         end
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int stall_left, run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            if (stall_left == 0 && run_left == 0) begin
               stall_left = gaps_enabled ? pick_gap() : 0;
               run_left   = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
               run_left--;
            end
         end
      end
   end

   initial begin : result_checker
      reorder_result_type want;
      yrmr_flags_type  got_flags;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_flags = yrmr_flags_type'(rsp_tuser);
            if (reorder_results_q.size() == 0) begin
               report_mismatch("result with nothing pending", -1, rsp_tdata);
            end else begin
               want = reorder_results_q.pop_front();
               if (want.flags.band_ready) bands_checked++;
               if (want.flags.pair_dropped) drops_checked++;
               if (rsp_tdata !== want.read_data)
                  report_mismatch("read_data", want.read_data, rsp_tdata);
               if (got_flags.band_ready !== want.flags.band_ready)
                  report_mismatch("band_ready", want.flags.band_ready, got_flags.band_ready);
               if (got_flags.first_band !== want.flags.first_band)
                  report_mismatch("first_band", want.flags.first_band, got_flags.first_band);
               if (got_flags.pair_dropped !== want.flags.pair_dropped)
                  report_mismatch("pair_dropped", want.flags.pair_dropped,
                                  got_flags.pair_dropped);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no item accepted for %0d cycles, %0d results pending",
               quiet, reorder_results_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_line_overflow();
      test_backpressure();
      test_random_frames(1300);
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d items and checked %0d results, with a %0d-cycle output hold-off.",
               items_sent, results_seen, HOLD_CYCLES);
      $display("Results held %0d completed bands and %0d dropped pairs; %0d mismatches.",
               bands_checked, drops_checked, mismatches);
      if (mismatches == 0 && reorder_results_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
